[src/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants for the sliding window maximum core and its deque memory.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned MaxWindowDef   = 1024;
  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned CfgWidth       = 11;

endpackage

[src/swm_deque_ram.sv]
// ----------------------------------------------------------------------------
// swm_deque_ram
// Single-port-write, single-port-read deque store with a registered read.
// ----------------------------------------------------------------------------
module swm_deque_ram #(
  parameter int unsigned Depth = swm_pkg::MaxWindowDef,
  parameter int unsigned Width = swm_pkg::SampleWidthDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sliding_window_maximum_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Maximum over the most recent window of signed samples, kept as a monotonic
// deque of (position, value) pairs in a synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: sample; tuser: first_of_sequence; tlast: last
// m_axis    out        tdata: window_max; tlast: last_window
// cfg       in         cfg_data_i: window_size
//
// Each sample passes through the idle, front-check and push steps, with a back-check
// step before the push when the deque is not empty after its front check. Every front
// entry that leaves the window and every back entry that is popped adds a step of its
// own, and a back pop that empties the deque goes straight to the push. The memory's
// single read port and its registered read set this. Pops are amortized one per push.
// Reset empties the deque by clearing its count; the memory itself is not cleared.
// A finished result waits in the output register while the next sample is taken;
// a sample whose result finds that register still full waits before its push.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core #(
  parameter int unsigned MAX_WINDOW   = swm_pkg::MaxWindowDef,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SampleWidthDef,
  parameter int unsigned DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DATA_WIDTH-1:0]         s_axis_tdata,   // sample
  input  logic                          s_axis_tuser,   // first_of_sequence
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [DATA_WIDTH-1:0]         m_axis_tdata,   // window_max
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swm_pkg::CfgWidth-1:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW = $clog2(2 * MAX_WINDOW);
  localparam int unsigned EW = PW + SAMPLE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRONT,
    S_BACK,
    S_PUSH
  } state_e;

  state_e                          state_q;
  logic [AW-1:0]                   head_q;
  logic [CW-1:0]                   count_q;
  logic [PW-1:0]                   pos_q;
  logic [CW-1:0]                   seen_q;
  logic [swm_pkg::CfgWidth-1:0]    win_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample_q;
  logic                            last_q;
  logic signed [SAMPLE_WIDTH-1:0]  front_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  out_data_q;
  logic                            out_last_q;

  logic [AW-1:0]                   raddr;
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [EW-1:0]                   wdata;
  logic [EW-1:0]                   rdata;
  logic signed [SAMPLE_WIDTH-1:0]  rd_val;
  logic [PW-1:0]                   rd_pos;
  logic [CW-1:0]                   w_eff;
  logic [31:0]                     age;
  logic                            too_old;
  logic [CW-1:0]                   seen_next;
  logic                            emit;
  logic                            push_stall;
  logic                            load_out;

  function automatic logic [AW-1:0] ring_idx(logic [AW-1:0] h, logic [CW-1:0] c,
                                             logic [1:0] back);
    logic [31:0] s;
    s = 32'(h) + 32'(c) - 32'(back);
    if (s >= 32'(MAX_WINDOW)) begin
      s = s - 32'(MAX_WINDOW);
    end
    return s[AW-1:0];
  endfunction

  swm_deque_ram #(
    .Depth (MAX_WINDOW),
    .Width (EW),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_val = rdata[SAMPLE_WIDTH-1:0];
  assign rd_pos = rdata[EW-1:SAMPLE_WIDTH];

  always_comb begin
    logic [31:0] wc;
    logic [31:0] w32;
    wc = 32'(win_q);
    if (wc == 32'd0) begin
      w32 = 32'd1;
    end else if (wc > 32'(MAX_WINDOW)) begin
      w32 = 32'(MAX_WINDOW);
    end else begin
      w32 = wc;
    end
    w_eff = w32[CW-1:0];
  end

  always_comb begin
    if (pos_q >= rd_pos) begin
      age = 32'(pos_q) - 32'(rd_pos);
    end else begin
      age = 32'(pos_q) + 32'(2 * MAX_WINDOW) - 32'(rd_pos);
    end
    too_old = (age >= 32'(w_eff));
  end

  always_comb begin
    logic [CW-1:0] s;
    s = (seen_q > w_eff) ? w_eff : seen_q;
    if (s < w_eff) begin
      s = s + CW'(1);
    end
    seen_next = s;
  end

  assign emit       = (seen_next == w_eff);
  assign push_stall = emit && out_valid_q && !m_axis_tready;
  assign load_out   = (state_q == S_PUSH) && !push_stall && emit;

  always_comb begin
    raddr = head_q;
    case (state_q)
      S_IDLE: begin
        raddr = s_axis_tuser ? '0 : head_q;
      end
      S_FRONT: begin
        if (too_old) begin
          raddr = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
        end else begin
          raddr = ring_idx(head_q, count_q, 2'd1);
        end
      end
      S_BACK: begin
        raddr = ring_idx(head_q, count_q, 2'd2);
      end
      default: begin
        raddr = head_q;
      end
    endcase
  end

  assign we    = (state_q == S_PUSH) && !push_stall;
  assign waddr = ring_idx(head_q, count_q, 2'd0);
  assign wdata = {pos_q, sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      seen_q      <= '0;
      win_q       <= swm_pkg::CfgWidth'(1);
      sample_q    <= '0;
      last_q      <= 1'b0;
      front_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sample_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            last_q   <= s_axis_tlast;
            if (s_axis_tuser) begin
              head_q  <= '0;
              count_q <= '0;
              pos_q   <= '0;
              seen_q  <= '0;
            end
            state_q <= S_FRONT;
          end
        end
        S_FRONT: begin
          if (count_q == '0) begin
            state_q <= S_PUSH;
          end else if (too_old) begin
            head_q  <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
            count_q <= count_q - CW'(1);
          end else begin
            front_q <= rd_val;
            state_q <= S_BACK;
          end
        end
        S_BACK: begin
          if (rd_val <= sample_q) begin
            count_q <= count_q - CW'(1);
            if (count_q == CW'(1)) begin
              state_q <= S_PUSH;
            end
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!push_stall) begin
            count_q <= count_q + CW'(1);
            pos_q   <= (pos_q == PW'(2 * MAX_WINDOW - 1)) ? '0 : pos_q + PW'(1);
            seen_q  <= seen_next;
            if (emit) begin
              out_data_q  <= (count_q == '0) ? sample_q : front_q;
              out_last_q  <= last_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_WIDTH'($unsigned(out_data_q));
  assign m_axis_tlast  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WINDOW))
    else $error("deque count exceeds its capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < 32'(MAX_WINDOW))
    else $error("deque head outside the memory");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_PUSH))
    else $error("result raised outside the push step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BACK) |-> (count_q != '0))
    else $error("back pop started on an empty deque");

endmodule
